// File: hw/rtl/ps_pack_header_parser_defines.svh
// assertion macros for the pack header parser
`ifndef PS_PACK_HEADER_PARSER_DEFINES_SVH
`define PS_PACK_HEADER_PARSER_DEFINES_SVH

// same-cycle implication
`define PSHP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pshp assertion failed");

// next-cycle implication
`define PSHP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pshp assertion failed");

`endif

// File: hw/rtl/pshp_pkg.sv
// package: types and constants of the program stream pack header parser
`timescale 1ns / 1ps

package pshp_pkg;

    localparam int SECTOR_BYTES_DEF = 2048;

    localparam logic [7:0] PACK_CODE    = 8'hBA;
    localparam logic [7:0] PRIV1_ID     = 8'hBD;
    localparam int         PTS_FLAG_BIT = 7;
    localparam logic [2:0] STUFF_MASK   = 3'd7;
    localparam logic [8:0] SCR_SCALE    = 9'd300;
    localparam logic [4:0] PES_BASE     = 5'd14;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_NO_PACK   = 2'd1,
        STATUS_NO_PACKET = 2'd2
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } byte_req_t;

    typedef struct packed {
        status_t     status;
        logic [7:0]  stream_id;
        logic        is_private;
        logic [41:0] scr_value;
        logic        scr_valid;
        logic [32:0] pts_value;
        logic        pts_valid;
    } result_req_t;

    // sector summary handed from the parser to the result stage
    typedef struct packed {
        status_t     status;
        logic [7:0]  stream_id;
        logic        is_private;
        logic [32:0] scr_base;
        logic [8:0]  scr_ext;
        logic        scr_valid;
        logic [32:0] pts_value;
        logic        pts_valid;
    } sector_sum_t;

endpackage

// File: hw/rtl/pshp_sector_parser.sv
// byte-position parser: start codes, stuffing, stream ids, scr and pts fields
`timescale 1ns / 1ps

module pshp_sector_parser #(
    parameter int SECTOR_BYTES = pshp_pkg::SECTOR_BYTES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  take,
    input  pshp_pkg::byte_req_t   req,
    input  logic                  report_private,
    output pshp_pkg::sector_sum_t sum
);

    localparam int OFFS_W = $clog2(SECTOR_BYTES + 1);
    localparam int CW     = (OFFS_W > 10) ? OFFS_W : 10;

    logic [OFFS_W-1:0] offs_reg, offs_next;
    logic [2:0]        stuff_reg, stuff_next;
    logic              pack_ok_reg, pack_ok_next;
    logic              packet_ok_reg, packet_ok_next;
    logic [7:0]        outer_id_reg, outer_id_next;
    logic [7:0]        pes_len_reg, pes_len_next;
    logic              pts_flag_reg, pts_flag_next;
    logic [7:0]        substream_reg, substream_next;
    logic [47:0]       scr_raw_reg, scr_raw_next;
    logic [39:0]       pts_raw_reg, pts_raw_next;

    logic [OFFS_W-1:0] pos;
    logic [OFFS_W-1:0] ps;
    logic [OFFS_W-1:0] ps_n;
    logic [OFFS_W-1:0] rel;
    logic [7:0]        b;
    logic              is_priv;

    assign pos = offs_reg;
    assign b   = req.data_byte;
    assign ps  = OFFS_W'(pshp_pkg::PES_BASE) + OFFS_W'(stuff_reg);
    assign rel = pos - ps;

    always_comb
    begin
        offs_next      = offs_reg;
        stuff_next     = stuff_reg;
        pack_ok_next   = pack_ok_reg;
        packet_ok_next = packet_ok_reg;
        outer_id_next  = outer_id_reg;
        pes_len_next   = pes_len_reg;
        pts_flag_next  = pts_flag_reg;
        substream_next = substream_reg;
        scr_raw_next   = scr_raw_reg;
        pts_raw_next   = pts_raw_reg;

        if (offs_reg < OFFS_W'(SECTOR_BYTES))
        begin
            offs_next = offs_reg + OFFS_W'(1);
            // pack start code
            if (pos < OFFS_W'(3))
            begin
                if (b != ((pos == OFFS_W'(2)) ? 8'h01 : 8'h00))
                begin
                    pack_ok_next = 1'b0;
                end
            end
            else if (pos == OFFS_W'(3))
            begin
                if (b != pshp_pkg::PACK_CODE)
                begin
                    pack_ok_next = 1'b0;
                end
            end
            if (pos >= OFFS_W'(4) && pos <= OFFS_W'(9))
            begin
                scr_raw_next = {scr_raw_reg[39:0], b};
            end
            if (pos == OFFS_W'(13))
            begin
                stuff_next = b[2:0] & pshp_pkg::STUFF_MASK;
            end
            // packet header, relative to the end of the stuffing
            if (pos >= ps)
            begin
                if (rel < OFFS_W'(3))
                begin
                    if (b != ((rel == OFFS_W'(2)) ? 8'h01 : 8'h00))
                    begin
                        packet_ok_next = 1'b0;
                    end
                end
                else if (rel == OFFS_W'(3))
                begin
                    outer_id_next = b;
                end
                else if (rel == OFFS_W'(7))
                begin
                    pts_flag_next = b[pshp_pkg::PTS_FLAG_BIT];
                end
                else if (rel == OFFS_W'(8))
                begin
                    pes_len_next = b;
                end
                if (rel >= OFFS_W'(9) && rel <= OFFS_W'(13))
                begin
                    pts_raw_next = {pts_raw_reg[31:0], b};
                end
                if (rel >= OFFS_W'(9) && CW'(rel) == CW'(9) + CW'(pes_len_reg))
                begin
                    substream_next = b;
                end
            end
        end
    end

    // sector summary from the state after this request
    assign ps_n    = OFFS_W'(pshp_pkg::PES_BASE) + OFFS_W'(stuff_next);
    assign is_priv = (outer_id_next == pshp_pkg::PRIV1_ID);

    always_comb
    begin
        sum = '0;
        if (!pack_ok_next || offs_next < OFFS_W'(4))
        begin
            sum.status = pshp_pkg::STATUS_NO_PACK;
        end
        else if (!packet_ok_next || offs_next < ps_n + OFFS_W'(4))
        begin
            sum.status = pshp_pkg::STATUS_NO_PACKET;
        end
        else
        begin
            sum.status = pshp_pkg::STATUS_OK;
        end
        if (pack_ok_next && offs_next >= OFFS_W'(10))
        begin
            sum.scr_valid = 1'b1;
            sum.scr_base  = {scr_raw_next[45:43], scr_raw_next[41:27], scr_raw_next[25:11]};
            sum.scr_ext   = scr_raw_next[9:1];
        end
        if (sum.status == pshp_pkg::STATUS_OK)
        begin
            sum.is_private = is_priv;
            sum.stream_id  = (is_priv && report_private) ? substream_next : outer_id_next;
            if (is_priv && pts_flag_next && offs_next >= ps_n + OFFS_W'(14))
            begin
                sum.pts_valid = 1'b1;
                sum.pts_value = {pts_raw_next[35:33], pts_raw_next[31:17], pts_raw_next[15:1]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offs_reg      <= '0;
            stuff_reg     <= '0;
            pack_ok_reg   <= 1'b1;
            packet_ok_reg <= 1'b1;
            outer_id_reg  <= '0;
            pes_len_reg   <= '0;
            pts_flag_reg  <= 1'b0;
            substream_reg <= '0;
            scr_raw_reg   <= '0;
            pts_raw_reg   <= '0;
        end
        else if (take)
        begin
            if (req.last_byte)
            begin
                // back to the start of a sector
                offs_reg      <= '0;
                stuff_reg     <= '0;
                pack_ok_reg   <= 1'b1;
                packet_ok_reg <= 1'b1;
                outer_id_reg  <= '0;
                pes_len_reg   <= '0;
                pts_flag_reg  <= 1'b0;
                substream_reg <= '0;
                scr_raw_reg   <= '0;
                pts_raw_reg   <= '0;
            end
            else
            begin
                offs_reg      <= offs_next;
                stuff_reg     <= stuff_next;
                pack_ok_reg   <= pack_ok_next;
                packet_ok_reg <= packet_ok_next;
                outer_id_reg  <= outer_id_next;
                pes_len_reg   <= pes_len_next;
                pts_flag_reg  <= pts_flag_next;
                substream_reg <= substream_next;
                scr_raw_reg   <= scr_raw_next;
                pts_raw_reg   <= pts_raw_next;
            end
        end
    end

endmodule

// File: hw/rtl/ps_pack_header_parser.sv
// top level: mpeg-2 program stream pack header parser
// takes one sector byte per cycle, bytes stall only while both result stages are full
// a result passes through the summary register, then the scr scaling stage
// throughput one byte per cycle while bytes are not stalled; the scr multiply sits alone in the second stage
// rst_n clears the sector state and the valid flags of both stages, report_private resets to 1
`timescale 1ns / 1ps

module ps_pack_header_parser #(
    parameter int SECTOR_BYTES = pshp_pkg::SECTOR_BYTES_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  byte_valid,
    output logic                  byte_ready,
    input  pshp_pkg::byte_req_t   byte_req,
    output logic                  result_valid,
    input  logic                  result_ready,
    output pshp_pkg::result_req_t result_req,
    input  logic                  cfg_we,
    input  logic                  cfg_wdata
);

    logic                  priv_mode_reg, priv_mode_next;
    logic                  sum_valid_reg, sum_valid_next;
    pshp_pkg::sector_sum_t sum_reg, sum_next;
    logic                  out_valid_reg, out_valid_next;
    pshp_pkg::result_req_t out_reg, out_next;
    pshp_pkg::sector_sum_t sum;
    logic                  take;
    logic                  out_load;

    assign out_load   = !out_valid_reg || result_ready;
    assign byte_ready = !sum_valid_reg || out_load;
    assign take       = byte_valid && byte_ready;

    pshp_sector_parser #(
        .SECTOR_BYTES (SECTOR_BYTES)
    ) u_parser (
        .clk            (clk),
        .rst_n          (rst_n),
        .take           (take),
        .req            (byte_req),
        .report_private (priv_mode_reg),
        .sum            (sum)
    );

    always_comb
    begin
        priv_mode_next = cfg_we ? cfg_wdata : priv_mode_reg;

        sum_valid_next = sum_valid_reg;
        sum_next       = sum_reg;
        if (take && byte_req.last_byte)
        begin
            sum_valid_next = 1'b1;
            sum_next       = sum;
        end
        else if (out_load)
        begin
            sum_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (out_load)
        begin
            out_valid_next       = sum_valid_reg;
            out_next.status      = sum_reg.status;
            out_next.stream_id   = sum_reg.stream_id;
            out_next.is_private  = sum_reg.is_private;
            out_next.scr_value   = 42'(sum_reg.scr_base) * 42'(pshp_pkg::SCR_SCALE)
                                 + 42'(sum_reg.scr_ext);
            out_next.scr_valid   = sum_reg.scr_valid;
            out_next.pts_value   = sum_reg.pts_value;
            out_next.pts_valid   = sum_reg.pts_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            priv_mode_reg <= 1'b1;
            sum_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            priv_mode_reg <= priv_mode_next;
            sum_valid_reg <= sum_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload stages
    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
        out_reg <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result_req   = out_reg;

endmodule

// File: hw/rtl/pshp_checker.sv
// port checker for the pack header parser, bound to the top level
`timescale 1ns / 1ps
`include "ps_pack_header_parser_defines.svh"

module pshp_checker (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  byte_valid,
    input logic                  byte_ready,
    input pshp_pkg::byte_req_t   byte_req,
    input logic                  result_valid,
    input logic                  result_ready,
    input pshp_pkg::result_req_t result_req,
    input logic                  cfg_we,
    input logic                  cfg_wdata
);

    // a waiting result holds
    `PSHP_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && !result_ready, result_valid && $stable(result_req))

    // bytes only stall behind a waiting result
    `PSHP_ASSERT_NOW(a_stall_cause, clk, rst_n, !byte_ready, result_valid)

    // failed packets carry no ids and no pts
    `PSHP_ASSERT_NOW(a_fail_clean, clk, rst_n, result_valid && result_req.status != pshp_pkg::STATUS_OK, result_req.stream_id == 8'h00 && !result_req.is_private && !result_req.pts_valid)

    // pts only for private stream 1
    `PSHP_ASSERT_NOW(a_pts_private, clk, rst_n, result_valid && result_req.pts_valid, result_req.is_private)

    // scr value reads zero when not valid
    `PSHP_ASSERT_NOW(a_zero_fields, clk, rst_n, result_valid && !result_req.scr_valid, result_req.scr_value == 42'd0)

endmodule

bind ps_pack_header_parser pshp_checker u_pshp_checker (.*);
